[rtl/core/lrfg_pkg.sv]
// ----------------------------------------------------------------------------
// lrfg_pkg
// Types, constants and constant tables shared by the LED ring frame generator.
// ----------------------------------------------------------------------------
package lrfg_pkg;

   localparam int RING_PIXELS = 60;
   localparam int PIX_W       = 6;
   localparam logic [PIX_W-1:0] LAST_PIXEL = PIX_W'(RING_PIXELS - 1);

   localparam int BINARY_BITS = 16;
   localparam int COUNT_W     = 16;

   localparam int BAR_OFFSET = 7000;
   localparam int BAR_STEP   = 748;

   localparam logic [7:0] FULL_LEVEL   = 8'd255;
   localparam logic [7:0] CHASE_RED    = 8'd28;
   localparam logic [7:0] CHASE_GREEN  = 8'd90;
   localparam logic [7:0] CHASE_BLUE   = 8'd28;
   localparam logic [7:0] MARK_LEVEL   = 8'd20;
   localparam logic [7:0] DIAL_LEVEL   = 8'd1;
   localparam logic [7:0] HOUR_SIDE    = 8'd30;
   localparam logic [7:0] GRAY_LAST    = 8'd254;

   typedef enum logic [2:0] {
      MODE_CHASE    = 3'd0,
      MODE_CLOCK    = 3'd1,
      MODE_GRADIENT = 3'd2,
      MODE_GRAY     = 3'd3,
      MODE_BINARY   = 3'd4,
      MODE_BAR      = 3'd5
   } mode_type;

   typedef struct packed {
      logic        func;
      logic [6:0]  sec_bcd;
      logic [6:0]  min_bcd;
      logic [5:0]  hour_bcd;
      logic [23:0] sensor_raw;
   } req_type;

   // everything one frame needs, captured when the tick is taken
   typedef struct packed {
      mode_type           mode;
      logic [PIX_W-1:0]   chase_red_pos;
      logic [PIX_W-1:0]   chase_green_pos;
      logic [PIX_W-1:0]   chase_blue_pos;
      logic [PIX_W-1:0]   grad_offset;
      logic [7:0]         gray;
      logic [COUNT_W-1:0] count;
      logic [PIX_W-1:0]   hour_pos;
      logic [PIX_W-1:0]   hour_prev;
      logic [PIX_W-1:0]   hour_next;
      logic [PIX_W-1:0]   min_pos;
      logic [PIX_W-1:0]   min_next;
      logic [PIX_W-1:0]   sec_pos;
      logic [7:0]         fade_up;
      logic [23:0]        sensor_raw;
   } frame_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef logic [7:0]  level_table_type [128];
   typedef logic [23:0] bar_table_type [RING_PIXELS];

   // 255*s/59 saturated to 255
   function automatic level_table_type build_fade_table();
      level_table_type t;
      int v;
      for (int i = 0; i < 128; i++) begin
         v = (255 * i) / 59;
         t[i] = (v > 255) ? 8'd255 : 8'(v);
      end
      return t;
   endfunction

   // low 8 bits of 255*i/60
   function automatic level_table_type build_grad_table();
      level_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 8'((255 * i) / RING_PIXELS);
      end
      return t;
   endfunction

   // pixel p lights when raw >= 7000 + 748*(p+1)
   function automatic bar_table_type build_bar_table();
      bar_table_type t;
      for (int i = 0; i < RING_PIXELS; i++) begin
         t[i] = 24'(BAR_OFFSET + BAR_STEP * (i + 1));
      end
      return t;
   endfunction

   function automatic logic [RING_PIXELS-1:0] build_mark_table();
      logic [RING_PIXELS-1:0] t;
      for (int i = 0; i < RING_PIXELS; i++) begin
         t[i] = ((i % 5) == 0);
      end
      return t;
   endfunction

   localparam level_table_type         FADE_TABLE = build_fade_table();
   localparam level_table_type         GRAD_TABLE = build_grad_table();
   localparam bar_table_type           BAR_TABLE  = build_bar_table();
   localparam logic [RING_PIXELS-1:0]  MARK_TABLE = build_mark_table();

endpackage

[rtl/core/led_ring_frame_generator.sv]
// ----------------------------------------------------------------------------
// led_ring_frame_generator
// Frame generator for a 60-pixel RGB ring with six button-selected modes.
// ----------------------------------------------------------------------------
// A display tick request produces one frame of 60 pixel responses, pixel 0
// to pixel 59, one per cycle unless the response side stalls, which holds
// the pixel counter; the request loads the frame register and the pixel
// counter, and each pixel passes through the response register. A button
// request advances the mode and produces nothing. The pixel counter sets the
// rate: a tick keeps the block busy while responses flow, and the next
// request of either kind is taken in the cycle the last pixel enters the
// response register, so frames run back to back. Mode is 5 (sensor bar) after reset.
module led_ring_frame_generator import lrfg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_func,
   input  logic [6:0]       req_sec_bcd,
   input  logic [6:0]       req_min_bcd,
   input  logic [5:0]       req_hour_bcd,
   input  logic [23:0]      req_sensor_raw,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_pixel_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_frame_last
);

   req_type   req;
   frame_type frame;
   logic      frame_free;
   logic      accept;
   logic      tick;
   logic      press;

   assign req = '{func: req_func, sec_bcd: req_sec_bcd, min_bcd: req_min_bcd,
                  hour_bcd: req_hour_bcd, sensor_raw: req_sensor_raw};

   assign req_stall = !frame_free;
   assign accept    = req_valid && frame_free;
   assign tick      = accept && !req_func;
   assign press     = accept && req_func;

   lrfg_frame_regs u_frame_regs (
      .clock (clock),
      .reset (reset),
      .tick  (tick),
      .press (press),
      .req   (req),
      .frame (frame)
   );

   lrfg_pixel_seq u_pixel_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (tick),
      .frame           (frame),
      .frame_free      (frame_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

[rtl/core/lrfg_frame_regs.sv]
// ----------------------------------------------------------------------------
// lrfg_frame_regs
// Display mode and animation counters, and the frame register that holds
// the decoded parameters of the frame being drawn.
// ----------------------------------------------------------------------------
module lrfg_frame_regs import lrfg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      tick,
   input  logic      press,
   input  req_type   req,
   output frame_type frame
);

   mode_type           mode_ff, mode_in;
   logic [PIX_W-1:0]   chase_ff, chase_in;
   logic [PIX_W-1:0]   grad_ff, grad_in;
   logic [7:0]         gray_ff, gray_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   frame_type          frame_ff, frame_in;

   logic [6:0] sec_val;
   logic [6:0] min_val;
   logic [6:0] hour_val;
   logic [3:0] hour12;
   logic [2:0] min_step;
   logic [7:0] hour_raw;
   logic [7:0] min_raw;
   logic [7:0] sec_raw;

   function automatic logic [6:0] bcd_to_bin(input logic [6:0] v);
      return 7'(({4'b0, v[6:4]} * 7'd10) + {3'b0, v[3:0]});
   endfunction

   // values stay within one turn of the ring either side
   function automatic logic [PIX_W-1:0] ring_wrap(input logic [7:0] v);
      if (v[7]) begin
         return PIX_W'(v + 8'(RING_PIXELS));
      end else if (v >= 8'(RING_PIXELS)) begin
         return PIX_W'(v - 8'(RING_PIXELS));
      end
      return PIX_W'(v);
   endfunction

   function automatic logic [PIX_W-1:0] ring_ahead(input logic [PIX_W-1:0] p,
                                                    input logic [1:0] k);
      logic [PIX_W:0] s;
      s = {1'b0, p} + {5'b0, k};
      return (s >= (PIX_W+1)'(RING_PIXELS)) ? PIX_W'(s - (PIX_W+1)'(RING_PIXELS))
                                              : PIX_W'(s);
   endfunction

   // clock hands, decoded straight from the request
   always_comb begin
      sec_val  = bcd_to_bin(req.sec_bcd);
      min_val  = bcd_to_bin(req.min_bcd);
      hour_val = bcd_to_bin({1'b0, req.hour_bcd});
      if (hour_val >= 7'd36) begin
         hour12 = 4'(hour_val - 7'd36);
      end else if (hour_val >= 7'd24) begin
         hour12 = 4'(hour_val - 7'd24);
      end else if (hour_val >= 7'd12) begin
         hour12 = 4'(hour_val - 7'd12);
      end else begin
         hour12 = 4'(hour_val);
      end
      min_step = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (min_val >= 7'(12 * k)) begin
            min_step = 3'(k);
         end
      end
      hour_raw = 8'(RING_PIXELS) - ({4'b0, hour12} * 8'd5) - {5'b0, min_step};
      min_raw  = 8'(RING_PIXELS) - {1'b0, min_val};
      sec_raw  = 8'(RING_PIXELS) - {1'b0, sec_val};
   end

   always_comb begin
      frame_in                 = frame_ff;
      frame_in.mode            = mode_ff;
      frame_in.chase_red_pos   = ring_ahead(chase_ff, 2'd1);
      frame_in.chase_green_pos = ring_ahead(chase_ff, 2'd2);
      frame_in.chase_blue_pos  = ring_ahead(chase_ff, 2'd3);
      frame_in.grad_offset     = grad_ff;
      frame_in.gray            = gray_ff;
      frame_in.count           = count_ff;
      frame_in.hour_pos        = ring_wrap(hour_raw);
      frame_in.hour_prev       = ring_wrap(hour_raw - 8'd1);
      frame_in.hour_next       = ring_wrap(hour_raw + 8'd1);
      frame_in.min_pos         = ring_wrap(min_raw);
      frame_in.min_next        = ring_wrap(min_raw + 8'd1);
      frame_in.sec_pos         = ring_wrap(sec_raw);
      frame_in.fade_up         = FADE_TABLE[sec_val];
      frame_in.sensor_raw      = req.sensor_raw;
   end

   always_comb begin
      mode_in  = mode_ff;
      chase_in = chase_ff;
      grad_in  = grad_ff;
      gray_in  = gray_ff;
      count_in = count_ff;
      if (press) begin
         case (mode_ff)
            MODE_CHASE:    mode_in = MODE_CLOCK;
            MODE_CLOCK:    mode_in = MODE_GRADIENT;
            MODE_GRADIENT: mode_in = MODE_GRAY;
            MODE_GRAY:     mode_in = MODE_BINARY;
            MODE_BINARY:   mode_in = MODE_BAR;
            default:       mode_in = MODE_CHASE;
         endcase
      end
      if (tick) begin
         case (mode_ff)
            MODE_CHASE:    chase_in = ring_ahead(chase_ff, 2'd1);
            MODE_GRADIENT: grad_in  = ring_ahead(grad_ff, 2'd1);
            MODE_GRAY:     gray_in  = (gray_ff >= GRAY_LAST) ? 8'd0 : gray_ff + 8'd1;
            MODE_BINARY:   count_in = count_ff + COUNT_W'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BAR;
         chase_ff <= '0;
         grad_ff  <= '0;
         gray_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         chase_ff <= chase_in;
         grad_ff  <= grad_in;
         gray_ff  <= gray_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         frame_ff <= frame_in;
      end
   end

   assign frame = frame_ff;

   a_chase_range: assert property (@(posedge clock) disable iff (reset)
      chase_ff <= LAST_PIXEL)
      else $error("chase position left the ring");

   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      grad_ff <= LAST_PIXEL)
      else $error("gradient offset left the ring");

   a_gray_range: assert property (@(posedge clock) disable iff (reset)
      gray_ff <= GRAY_LAST)
      else $error("gray level reached full scale");

   a_press_only_mode: assert property (@(posedge clock) disable iff (reset)
      press |=> ($stable(chase_ff) && $stable(gray_ff) && $stable(count_ff)))
      else $error("button press moved an animation counter");

endmodule

[rtl/core/lrfg_pixel_color.sv]
// ----------------------------------------------------------------------------
// lrfg_pixel_color
// Color of one ring pixel from the frame parameters and the pixel index.
// ----------------------------------------------------------------------------
module lrfg_pixel_color import lrfg_pkg::*; (
   input  frame_type        frame,
   input  logic [PIX_W-1:0] pix,
   output color_type        color
);

   always_comb begin
      color = '0;
      case (frame.mode)
         MODE_CHASE: begin
            if (pix == frame.chase_red_pos)   color.red   = CHASE_RED;
            if (pix == frame.chase_green_pos) color.green = CHASE_GREEN;
            if (pix == frame.chase_blue_pos)  color.blue  = CHASE_BLUE;
         end
         MODE_CLOCK: begin
            if (MARK_TABLE[pix]) begin
               color = '{red: MARK_LEVEL, green: MARK_LEVEL, blue: 8'd0};
            end else begin
               color = '{red: DIAL_LEVEL, green: DIAL_LEVEL, blue: DIAL_LEVEL};
            end
            // later hands draw over earlier ones
            if (pix == frame.hour_pos) begin
               color = '{red: FULL_LEVEL, green: 8'd0, blue: 8'd0};
            end
            if (pix == frame.hour_prev) begin
               color = '{red: HOUR_SIDE, green: 8'd0, blue: 8'd0};
            end
            if (pix == frame.hour_next) begin
               color = '{red: HOUR_SIDE, green: 8'd0, blue: 8'd0};
            end
            if (pix == frame.min_pos) begin
               color = '{red: 8'd0, green: frame.fade_up, blue: 8'd0};
            end
            if (pix == frame.min_next) begin
               color = '{red: 8'd0, green: FULL_LEVEL - frame.fade_up, blue: 8'd0};
            end
            if (pix == frame.sec_pos) begin
               color = '{red: 8'd0, green: 8'd0, blue: FULL_LEVEL};
            end
         end
         MODE_GRADIENT: begin
            color.green = GRAD_TABLE[{1'b0, pix} + {1'b0, frame.grad_offset}];
         end
         MODE_GRAY: begin
            color = '{red: frame.gray, green: frame.gray, blue: frame.gray};
         end
         MODE_BINARY: begin
            if ((pix < PIX_W'(BINARY_BITS)) && frame.count[pix[3:0]]) begin
               color.red = FULL_LEVEL;
            end
         end
         MODE_BAR: begin
            if (frame.sensor_raw >= BAR_TABLE[pix]) begin
               color.red   = 8'(pix);
               color.green = 8'(PIX_W'(RING_PIXELS) - pix);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/lrfg_pixel_seq.sv]
// ----------------------------------------------------------------------------
// lrfg_pixel_seq
// Ring pixel counter and result register, one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
module lrfg_pixel_seq import lrfg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  frame_type        frame,
   output logic             frame_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_pixel_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_frame_last
);

   logic             busy_ff, busy_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] out_pix_ff;
   color_type        out_color_ff;
   logic             out_last_ff;
   color_type        color;
   logic             advance;
   logic             done;

   lrfg_pixel_color u_color (
      .frame (frame),
      .pix   (pix_ff),
      .color (color)
   );

   assign advance    = busy_ff && (!valid_ff || !rsp_stall);
   assign done       = advance && (pix_ff == LAST_PIXEL);
   assign frame_free = !busy_ff || done;

   always_comb begin
      busy_in = busy_ff;
      pix_in  = pix_ff;
      if (advance) begin
         pix_in = pix_ff + PIX_W'(1);
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         pix_in  = '0;
      end
      valid_in = advance || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pix_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pix_ff   <= pix_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pix_ff   <= pix_ff;
         out_color_ff <= color;
         out_last_ff  <= (pix_ff == LAST_PIXEL);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_index = out_pix_ff;
   assign rsp_red         = out_color_ff.red;
   assign rsp_green       = out_color_ff.green;
   assign rsp_blue        = out_color_ff.blue;
   assign rsp_frame_last  = out_last_ff;

   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pix_ff <= LAST_PIXEL))
      else $error("pixel counter ran past the ring");

   a_start_free: assert property (@(posedge clock) disable iff (reset)
      start |-> frame_free)
      else $error("frame started over one still drawing");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (done && !start) |=> !busy_ff)
      else $error("sequencer stayed busy after the last pixel");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_last_ff) |-> (out_pix_ff == LAST_PIXEL))
      else $error("end of frame flagged on the wrong pixel");

   a_start_first: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && (pix_ff == '0)))
      else $error("frame did not start at pixel zero");

endmodule
